// ===== rtl/block_average_ema_filter_core_defines.svh =====
// Assertion macros for the block average / EMA filter core.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef BLOCK_AVERAGE_EMA_FILTER_CORE_DEFINES_SVH
`define BLOCK_AVERAGE_EMA_FILTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every rising edge outside reset
`define BAE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define BAE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BAE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAE_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/baef_pkg.sv =====
// Shared types and constants for the block average / EMA filter core.
// No dependencies.
package baef_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COUNT_W    = 8;
    localparam int ALPHA_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WEIGHT = 2'd1;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 8'd8;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET        = 9'd26;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE          = 9'd256;

    typedef struct packed {
        logic take_sample;  // input item accepted this cycle
        logic div_step;     // one restoring divide step
        logic mul;          // alpha * mean
        logic blend;        // update or seed the smoothed level
        logic load_out;     // capture result payload
    } t_cmd;

    typedef struct packed {
        logic batch_end;    // presented sample completes the batch
        logic first;        // next level update seeds the filter
    } t_status;

endpackage

// ===== rtl/baef_ctrl.sv =====
// Controller for the block average / EMA filter core: sequencer and result valid.
// Depends on baef_pkg and the assertion macro header.
`include "block_average_ema_filter_core_defines.svh"

module baef_ctrl
    import baef_pkg::*;
#(
    parameter int SUM_W = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_stall,
    output logic    o_result_valid,
    input  logic    i_result_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_MUL   = 5'b00100,
        S_BLEND = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                accept;

    assign accept   = i_sample_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_result_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_result_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take_sample = accept;
                if (accept && i_status.batch_end) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = i_status.first ? S_BLEND : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_sample_stall = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;

    // a held result must never be overwritten
    `BAE_NEVER(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out && r_out_valid && i_result_stall, "result overwritten while stalled")
    // a fresh result only follows the output state
    `BAE_ASSERT(a_valid_from_out, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result valid without output step")
    // divide step count stays inside the dividend width
    `BAE_NEVER(a_step_range, i_clk, i_rst_n, (r_state == S_DIV) && (r_step > STEP_W'(SUM_W - 1)), "divide step overrun")
    // the divider leaves only towards the level update
    `BAE_ASSERT(a_div_exit, i_clk, i_rst_n, (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_MUL || r_state == S_BLEND), "bad exit from divide")

endmodule

// ===== rtl/baef_datapath.sv =====
// Datapath for the block average / EMA filter core: batch sum, serial divider,
// level blend, configuration and result registers. Depends on baef_pkg.
module baef_datapath
    import baef_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_SAMPLES = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic [SAMPLE_BITS-1:0] o_batch_mean,
    output logic [SAMPLE_BITS-1:0] o_filtered_level
);

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int LEVEL_W = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_W  = ALPHA_W + SAMPLE_BITS;
    localparam int ACC_W   = PROD_W + FRAC_BITS + 1;

    logic [COUNT_W-1:0]     r_sample_count;
    logic [ALPHA_W-1:0]     r_alpha;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_taken;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_first;
    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_div;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] r_mean_out;
    logic [SAMPLE_BITS-1:0] r_level_out;

    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       taken_next;
    logic [CMP_W-1:0]       batch_len;
    logic                   batch_end;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W:0]         rem_diff;
    logic                   rem_ge;
    logic [SAMPLE_BITS-1:0] mean;
    logic [ALPHA_W-1:0]     alpha_sat;
    logic [ALPHA_W-1:0]     alpha_inv;
    logic [ACC_W-1:0]       acc;

    // zero count acts as one; counts above the capacity saturate
    always_comb begin
        batch_len = CMP_W'(r_sample_count);
        if (r_sample_count == '0) begin
            batch_len = CMP_W'(1);
        end
        if (batch_len > CMP_W'(MAX_SAMPLES)) begin
            batch_len = CMP_W'(MAX_SAMPLES);
        end
    end

    assign sum_next   = r_sum + SUM_W'(i_sample);
    assign taken_next = r_taken + CNT_W'(1);
    assign batch_end  = CMP_W'(taken_next) >= batch_len;

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    // quotient never exceeds the largest sample value
    assign mean = r_quo[SAMPLE_BITS-1:0];

    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign alpha_inv = ALPHA_ONE - alpha_sat;
    assign acc = ACC_W'({r_prod, {FRAC_BITS{1'b0}}})
               + (ACC_W'(alpha_inv) * ACC_W'(r_level))
               + ACC_W'(1 << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RESET;
            r_alpha        <= ALPHA_RESET;
            r_sum          <= '0;
            r_taken        <= '0;
            r_level        <= '0;
            r_first        <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_ALPHA_WEIGHT: r_alpha        <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.take_sample) begin
                if (batch_end) begin
                    r_sum   <= '0;
                    r_taken <= '0;
                end else begin
                    r_sum   <= sum_next;
                    r_taken <= taken_next;
                end
            end
            if (i_cmd.blend) begin
                r_first <= 1'b0;
                if (r_first) begin
                    r_level <= {mean, {FRAC_BITS{1'b0}}};
                end else begin
                    r_level <= acc[FRAC_BITS +: LEVEL_W];
                end
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample && batch_end) begin
            r_quo <= sum_next;
            r_rem <= '0;
            r_div <= taken_next;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(alpha_sat) * PROD_W'(mean);
        end
        if (i_cmd.load_out) begin
            r_mean_out  <= mean;
            r_level_out <= r_level[LEVEL_W-1:FRAC_BITS];
        end
    end

    assign o_status.batch_end = batch_end;
    assign o_status.first     = r_first;
    assign o_batch_mean       = r_mean_out;
    assign o_filtered_level   = r_level_out;

endmodule

// ===== rtl/block_average_ema_filter_core.sv =====
// Block average then exponential moving average: samples are summed into batches
// of sample_count, each batch mean seeds or updates a Q12.8 smoothed level. A sample
// that does not close a batch is only added to the sum. A closing sample runs the
// one-bit-per-cycle restoring divider, a step per bit of the batch sum, then the
// multiply (skipped for the first batch, which seeds the level) and blend steps;
// input stall is high from then until the result is loaded, also while it waits
// for the previous result to be taken. Configuration port is always ready; writes
// to unknown indexes are ignored. Depends on baef_pkg, baef_ctrl and baef_datapath.
module block_average_ema_filter_core
    import baef_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_SAMPLES = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample_valid,
    output logic                   o_sample_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_result_valid,
    input  logic                   i_result_stall,
    output logic [SAMPLE_BITS-1:0] o_batch_mean,
    output logic [SAMPLE_BITS-1:0] o_filtered_level,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES + 1);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    baef_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    baef_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_batch_mean     (o_batch_mean),
        .o_filtered_level (o_filtered_level)
    );

endmodule
